// File: rtl/ip_address_pool_allocator_unit_defines.svh
// Assertion macros shared by the address pool allocator RTL.
`ifndef IP_ADDRESS_POOL_ALLOCATOR_UNIT_DEFINES_SVH
`define IP_ADDRESS_POOL_ALLOCATOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// A property checked on every clock edge outside reset.
`define APAU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A condition that must be followed by another one on the next clock edge.
`define APAU_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`else

`define APAU_ASSERT(lbl, prop, msg)
`define APAU_ASSERT_NEXT(lbl, pre, post, msg)

`endif

`endif

// File: rtl/apau_pkg.sv
// Types and fixed constants of the address pool allocator.
package apau_pkg;

  // Request codes.
  localparam logic REQ_LEASE   = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  // Result status codes.
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_INVALID = 1'b1;

  // Configuration register indexes.
  localparam logic CFG_NETWORK = 1'b0;
  localparam logic CFG_PREFIX  = 1'b1;

  localparam int          ADDR_BITS      = 32;
  localparam int          PFX_BITS       = 5;
  localparam logic [4:0]  PFX_MAX        = 5'd30;
  localparam logic [4:0]  PFX_RESET      = 5'd24;

  // Widest map word index supported by the scan unit.
  localparam int SCAN_IDX_BITS = 4;

  typedef struct packed {
    logic                     found;
    logic [SCAN_IDX_BITS-1:0] idx;
  } scan_res_t;

endpackage

// File: rtl/apau_map_ram.sv
// Allocation map storage: one write port and one registered read port.
module apau_map_ram #(
  parameter int ADDR_BITS = 4,
  parameter int DATA_BITS = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [DATA_BITS-1:0] wdata,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [DATA_BITS-1:0] rdata
);

  logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/apau_word_scan.sv
// Finds the lowest free host of one map word inside an optional low and high bound.
module apau_word_scan #(
  parameter int WB = 4
) (
  input  logic [(2**WB)-1:0] word,
  input  logic               use_lo,
  input  logic [WB-1:0]      lo_bits,
  input  logic               use_hi,
  input  logic [WB-1:0]      hi_bits,
  output apau_pkg::scan_res_t res
);
  import apau_pkg::*;

  localparam int W = 2**WB;

  logic [W-1:0] lo_mask;
  logic [W-1:0] hi_mask;
  logic [W-1:0] cand;

  // Shifting all ones right by (W-1-hi) keeps bits 0..hi; ~hi_bits is that amount.
  assign lo_mask = use_lo ? ({W{1'b1}} << lo_bits) : {W{1'b1}};
  assign hi_mask = use_hi ? ({W{1'b1}} >> (~hi_bits)) : {W{1'b1}};
  assign cand    = ~word & lo_mask & hi_mask;

  always_comb begin
    res.found = 1'b0;
    res.idx   = '0;
    for (int i = W - 1; i >= 0; i--) begin
      if (cand[i]) begin
        res.found = 1'b1;
        res.idx   = SCAN_IDX_BITS'(i);
      end
    end
  end

endmodule

// File: rtl/ip_address_pool_allocator_unit.sv
// Top level of the IPv4 address pool allocator: sequencer, map and scan unit.
//
//   Channel  Handshake              Payload
//   in       in_valid / in_ready    req_type, address
//   out      out_valid / out_ready  status, granted_address, free_count
//   cfg      cfg_write              cfg_index, cfg_data
//
// A release or a lease of a free host passes through accept, check and commit; its result
// is loaded into the output register at commit. A mismatch or empty pool skips the check.
// A lease of a used host also scans the map words of 2^WB hosts, at most two passes over
// the words of the subnet when the scan wraps to host 1. After reset and after each
// configuration write the map is swept, one word a cycle, over all 2^(HOST_BITS-WB) words
// (16 at the default size); no transaction is accepted meanwhile. A result waits in the
// output register while out_ready is low, and the next transaction is accepted while it
// waits; it stalls only at its own commit.
`include "ip_address_pool_allocator_unit_defines.svh"

module ip_address_pool_allocator_unit #(
  parameter int HOST_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic                  cfg_index,
  input  logic [31:0]           cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  req_type,
  input  logic [31:0]           address,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  status,
  output logic [31:0]           granted_address,
  output logic [HOST_BITS:0]    free_count
);
  import apau_pkg::*;

  localparam int HB = HOST_BITS;
  localparam int WB = (HB > SCAN_IDX_BITS) ? SCAN_IDX_BITS : HB - 1;
  localparam int W  = 2**WB;
  localparam int AB = HB - WB;
  localparam logic [4:0]  PFX_MIN     = 5'(32 - HB);
  localparam logic [HB:0] RESERVED_CT = (HB+1)'(3);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_CHECK  = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_COMMIT = 3'd4;

  // Registers.
  logic [2:0]          state;
  logic [AB-1:0]       ptr;
  logic                req_r;
  logic [HB-1:0]       host_r;
  logic [HB-1:0]       lo_r;
  logic                phase_r;
  logic                ok_r;
  logic [HB:0]         used_count;
  logic [31:0]         network_address;
  logic [PFX_BITS-1:0] prefix_length;

  logic [2:0]    state_next;
  logic [AB-1:0] ptr_next;
  logic          req_next;
  logic [HB-1:0] host_next;
  logic [HB-1:0] lo_next;
  logic          phase_next;
  logic          ok_next;

  // Subnet geometry.
  logic [4:0]    pfx_eff;
  logic [31:0]   host_mask;
  logic [31:0]   net_kept;
  logic [HB-1:0] host_last;
  logic [HB-1:0] host_prev;
  logic [HB-1:0] hi_host;
  logic [HB:0]   n_hosts;
  logic [AB-1:0] hi_word;
  logic [AB-1:0] res_word;

  logic          in_net_ok;
  logic [HB-1:0] in_host;
  logic [HB-1:0] scan_start;
  logic          bit_used;
  logic [W-1:0]  bit_mask;
  logic [W-1:0]  clr_word;
  logic [HB:0]   used_after;

  logic          mem_we;
  logic [W-1:0]  mem_wdata;
  logic [W-1:0]  rdata;
  logic          out_load;
  scan_res_t     scan;

  always_comb begin
    if (prefix_length < PFX_MIN) begin
      pfx_eff = PFX_MIN;
    end else if (prefix_length > PFX_MAX) begin
      pfx_eff = PFX_MAX;
    end else begin
      pfx_eff = prefix_length;
    end
  end

  assign host_mask = 32'hFFFF_FFFF >> pfx_eff;
  assign net_kept  = network_address & ~host_mask;
  assign host_last = host_mask[HB-1:0];
  assign host_prev = host_last - HB'(1);
  assign hi_host   = host_last - HB'(2);
  assign n_hosts   = {1'b0, host_last} + (HB+1)'(1);
  assign hi_word   = hi_host[HB-1:WB];
  assign res_word  = host_last[HB-1:WB];

  assign in_net_ok  = (address & ~host_mask) == net_kept;
  assign in_host    = address[HB-1:0] & host_last;
  // The scan visits hosts 1 .. all-ones-minus-two, starting just past the request.
  assign scan_start = (host_r >= hi_host) ? HB'(1) : host_r + HB'(1);
  assign bit_used   = rdata[host_r[WB-1:0]];
  assign bit_mask   = W'(1) << host_r[WB-1:0];

  // Init pattern: host 0 and the two top hosts of the subnet are reserved.
  assign clr_word = ((ptr == '0) ? W'(1) : '0)
                  | ((ptr == res_word) ? ((W'(1) << host_last[WB-1:0])
                                         | (W'(1) << host_prev[WB-1:0])) : '0);

  assign in_ready = (state == S_IDLE);

  apau_word_scan #(
    .WB(WB)
  ) u_scan (
    .word    (rdata),
    .use_lo  (ptr == lo_r[HB-1:WB]),
    .lo_bits (lo_r[WB-1:0]),
    .use_hi  (ptr == hi_word),
    .hi_bits (hi_host[WB-1:0]),
    .res     (scan)
  );

  // The read address is the next pointer, so rdata holds the word at ptr when read.
  apau_map_ram #(
    .ADDR_BITS(AB),
    .DATA_BITS(W)
  ) u_map (
    .clk   (clk),
    .we    (mem_we),
    .waddr (ptr),
    .wdata (mem_wdata),
    .raddr (ptr_next),
    .rdata (rdata)
  );

  always_comb begin
    state_next = state;
    ptr_next   = ptr;
    req_next   = req_r;
    host_next  = host_r;
    lo_next    = lo_r;
    phase_next = phase_r;
    ok_next    = ok_r;
    mem_we     = 1'b0;
    mem_wdata  = rdata;
    out_load   = 1'b0;
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = clr_word;
        ptr_next  = ptr + AB'(1);
        if (ptr == '1) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          req_next  = req_type;
          host_next = in_host;
          ptr_next  = in_host[HB-1:WB];
          if (!in_net_ok || (req_type == REQ_LEASE && used_count >= n_hosts)) begin
            ok_next    = 1'b0;
            state_next = S_COMMIT;
          end else begin
            state_next = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (req_r == REQ_RELEASE) begin
          ok_next    = bit_used;
          state_next = S_COMMIT;
        end else if (!bit_used) begin
          ok_next    = 1'b1;
          state_next = S_COMMIT;
        end else begin
          lo_next    = scan_start;
          phase_next = 1'b0;
          ptr_next   = scan_start[HB-1:WB];
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan.found) begin
          host_next  = {ptr, scan.idx[WB-1:0]};
          ok_next    = 1'b1;
          state_next = S_COMMIT;
        end else if (ptr == hi_word) begin
          if (!phase_r) begin
            // Wrap around and search again from host 1.
            phase_next = 1'b1;
            lo_next    = HB'(1);
            ptr_next   = '0;
          end else begin
            ok_next    = 1'b0;
            state_next = S_COMMIT;
          end
        end else begin
          ptr_next = ptr + AB'(1);
        end
      end
      S_COMMIT: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
          mem_we     = ok_r;
          mem_wdata  = (req_r == REQ_LEASE) ? (rdata | bit_mask) : (rdata & ~bit_mask);
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_comb begin
    used_after = used_count;
    if (ok_r) begin
      used_after = (req_r == REQ_LEASE) ? used_count + (HB+1)'(1)
                                        : used_count - (HB+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_CLEAR;
      ptr             <= '0;
      used_count      <= RESERVED_CT;
      network_address <= '0;
      prefix_length   <= PFX_RESET;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_NETWORK: network_address <= cfg_data;
          CFG_PREFIX:  prefix_length   <= cfg_data[PFX_BITS-1:0];
          default:     network_address <= network_address;
        endcase
        state      <= S_CLEAR;
        ptr        <= '0;
        used_count <= RESERVED_CT;
      end else begin
        state <= state_next;
        ptr   <= ptr_next;
        if (out_load) begin
          used_count <= used_after;
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r   <= req_next;
    host_r  <= host_next;
    lo_r    <= lo_next;
    phase_r <= phase_next;
    ok_r    <= ok_next;
    if (out_load) begin
      status          <= ok_r ? STATUS_OK : STATUS_INVALID;
      granted_address <= (ok_r && req_r == REQ_LEASE) ? (net_kept | 32'(host_r)) : '0;
      free_count      <= n_hosts - used_after;
    end
  end

  `APAU_ASSERT(a_used_in_range, used_count <= n_hosts, "used count exceeds subnet size")
  `APAU_ASSERT(a_scan_bounded, (state == S_SCAN) |-> (ptr <= hi_word),
               "scan ran past last host")
  `APAU_ASSERT_NEXT(a_used_stable, (state != S_COMMIT) && !cfg_write,
                    $stable(used_count), "used count moved outside commit")
  `APAU_ASSERT_NEXT(a_release_no_grant, out_load && (req_r == REQ_RELEASE),
                    granted_address == '0, "release returned an address")

endmodule

// File: tb/sv/tb_ip_address_pool_allocator_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for the IPv4 address pool allocator with a lease ledger scoreboard.

module tb_ip_address_pool_allocator_unit;
  import apau_pkg::*;

  typedef struct {
    logic        status;
    logic [31:0] granted;
    logic [8:0]  free;
  } lease_result_t;

  // Tracks the pool as the block should see it and checks each result transaction.
  class lease_ledger;
    localparam int HB = 8;

    bit            used_map[1 << HB];
    int unsigned   used_hosts;
    logic [31:0]   net_reg;
    logic [4:0]    pfx_reg;
    lease_result_t awaited_results[$];
    int            mismatches;

    function new();
      net_reg    = '0;
      pfx_reg    = PFX_RESET;
      mismatches = 0;
      rebuild_pool();
    endfunction

    // Prefix lengths outside the supported range are clamped.
    function int unsigned host_width();
      int unsigned p;
      p = pfx_reg;
      if (p < 32 - HB) p = 32 - HB;
      if (p > 30) p = 30;
      return 32 - p;
    endfunction

    function logic [31:0] net_mask();
      return ~(32'hFFFF_FFFF >> (32 - host_width()));
    endfunction

    function logic [31:0] subnet_base();
      return net_reg & net_mask();
    endfunction

    function void rebuild_pool();
      int unsigned n;
      n = 1 << host_width();
      foreach (used_map[i]) used_map[i] = 1'b0;
      used_map[0]     = 1'b1;
      used_map[n - 1] = 1'b1;
      used_map[n - 2] = 1'b1;
      used_hosts      = 3;
    endfunction

    function void set_register(logic idx, logic [31:0] data);
      if (idx == CFG_NETWORK) net_reg = data;
      else pfx_reg = data[4:0];
      rebuild_pool();
    endfunction

    function void note_request(logic rq, logic [31:0] addr);
      int unsigned   n;
      int unsigned   host;
      int unsigned   cur;
      bit            found;
      logic [31:0]   base;
      lease_result_t res;
      n           = 1 << host_width();
      base        = subnet_base();
      host        = addr & (n - 1);
      res.status  = STATUS_INVALID;
      res.granted = '0;
      if ((addr & net_mask()) == base) begin
        if (rq == REQ_LEASE) begin
          if (used_hosts < n) begin
            cur   = host;
            found = !used_map[host];
            // Scan upward, wrapping to host 1 past the top leasable host.
            for (int i = 0; i < n && !found; i++) begin
              cur   = (cur >= n - 3) ? 1 : cur + 1;
              found = !used_map[cur];
            end
            if (found) begin
              used_map[cur] = 1'b1;
              used_hosts++;
              res.status  = STATUS_OK;
              res.granted = base | cur;
            end
          end
        end else if (used_map[host]) begin
          used_map[host] = 1'b0;
          used_hosts--;
          res.status = STATUS_OK;
        end
      end
      res.free = 9'(n - used_hosts);
      awaited_results.push_back(res);
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      $display("%0t: MISMATCH %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    task check_result(logic st, logic [31:0] ga, logic [8:0] fc);
      lease_result_t res;
      if (awaited_results.size() == 0) begin
        report_mismatch("result with no pending transaction", {31'b0, st}, 32'b0);
      end else begin
        res = awaited_results.pop_front();
        if (st !== res.status) report_mismatch("status", {31'b0, st}, {31'b0, res.status});
        if (ga !== res.granted) report_mismatch("granted_address", ga, res.granted);
        if (fc !== res.free) report_mismatch("free_count", {23'b0, fc}, {23'b0, res.free});
      end
    endtask
  endclass

  localparam int HOST_BITS   = 8;
  localparam int HOLD_CYCLES = 150;

  logic                 clk;
  logic                 rst;
  logic                 cfg_write;
  logic                 cfg_index;
  logic [31:0]          cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic                 req_type;
  logic [31:0]          address;
  logic                 out_valid;
  logic                 out_ready;
  logic                 status;
  logic [31:0]          granted_address;
  logic [HOST_BITS:0]   free_count;

  lease_ledger ledger;
  bit          hold_output;
  bit          send_calm;
  int          send_run;
  bit          recv_calm;
  int          recv_run;

  ip_address_pool_allocator_unit #(
    .HOST_BITS(HOST_BITS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .req_type(req_type),
    .address(address),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .granted_address(granted_address),
    .free_count(free_count)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Gaps come in runs: some runs idle at random, others not at all.
  function automatic int draw_gap(inout bit calm, inout int run_left);
    if (run_left <= 0) begin
      calm     = ($urandom_range(0, 3) == 0);
      run_left = $urandom_range(5, 40);
    end
    run_left--;
    return calm ? 0 : $urandom_range(0, 19);
  endfunction

  task automatic send_request(input logic rq, input logic [31:0] addr);
    int gap;
    gap = draw_gap(send_calm, send_run);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    req_type = rq;
    address  = addr;
    do @(posedge clk); while (!in_ready);
    ledger.note_request(rq, addr);
    @(negedge clk);
  endtask

  task automatic load_reg(input logic idx, input logic [31:0] data);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    ledger.set_register(idx, data);
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  // Waits for every outstanding result, then lets a worst-case scan drain.
  task automatic settle();
    while (ledger.awaited_results.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic run_phase(input logic [31:0] net_data, input logic [31:0] pfx_data,
                           input int count, input int lease_pct, input bit squeeze);
    int          hb;
    int          pick;
    logic        rq;
    logic [31:0] addr;
    logic [31:0] base;
    settle();
    load_reg(CFG_NETWORK, net_data);
    load_reg(CFG_PREFIX, pfx_data);
    hb   = ledger.host_width();
    base = ledger.subnet_base();
    for (int i = 0; i < count; i++) begin
      if (squeeze && i == 25) hold_output = 1'b1;
      rq   = ($urandom_range(0, 99) < lease_pct) ? REQ_LEASE : REQ_RELEASE;
      pick = $urandom_range(0, 99);
      addr = base | ($urandom() & ((32'd1 << hb) - 1));
      if (pick < 8) addr = $urandom();
      else if (pick < 13) addr ^= 32'd1 << $urandom_range(hb, 31);
      send_request(rq, addr);
    end
    in_valid = 1'b0;
  endtask

  // Result side: random back-pressure plus one long hold-off on request.
  initial begin
    int stall;
    out_ready = 1'b0;
    do @(negedge clk); while (rst);
    forever begin
      if (hold_output) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_output = 1'b0;
      end
      stall = draw_gap(recv_calm, recv_run);
      if (stall != 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      ledger.check_result(status, granted_address, free_count);
      @(negedge clk);
    end
  end

  initial begin
    ledger      = new();
    hold_output = 1'b0;
    send_run    = 0;
    recv_run    = 0;
    rst         = 1'b1;
    cfg_write   = 1'b0;
    cfg_index   = CFG_NETWORK;
    cfg_data    = '0;
    in_valid    = 1'b0;
    req_type    = REQ_LEASE;
    address     = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset subnet 0.0.0.0/24: wrap of the scan, reserved hosts, mismatches.
    send_request(REQ_LEASE,   32'h0000_0000);
    send_request(REQ_LEASE,   32'h0000_00FF);
    send_request(REQ_LEASE,   32'hFFFF_FFFF);
    send_request(REQ_RELEASE, 32'hFFFF_FFFF);
    send_request(REQ_RELEASE, 32'h0000_0007);
    send_request(REQ_LEASE,   32'h0000_00FD);
    send_request(REQ_RELEASE, 32'h0000_00FD);
    send_request(REQ_RELEASE, 32'h0000_0000);
    send_request(REQ_LEASE,   32'h0000_0000);
    in_valid = 1'b0;

    // Smallest subnet at the top of the address space: empty pool and a fruitless scan.
    settle();
    load_reg(CFG_NETWORK, 32'hFFFF_FFFF);
    load_reg(CFG_PREFIX, 32'd30);
    send_request(REQ_LEASE,   32'hFFFF_FFFD);
    send_request(REQ_LEASE,   32'hFFFF_FFFD);
    send_request(REQ_RELEASE, 32'hFFFF_FFFF);
    send_request(REQ_LEASE,   32'hFFFF_FFFC);
    send_request(REQ_LEASE,   32'hFFFF_FFFF);
    send_request(REQ_RELEASE, 32'hFFFF_FFFE);
    send_request(REQ_RELEASE, 32'hFFFF_FFFE);
    send_request(REQ_RELEASE, 32'h7FFF_FFFE);
    send_request(REQ_LEASE,   32'hFFFF_FFFE);
    in_valid = 1'b0;

    run_phase($urandom(), 32'd28, 70, 60, 1'b0);
    run_phase($urandom(), $urandom() & 32'hFFFF_FFE0, 50, 60, 1'b0);
    run_phase(32'hFFFF_FFFF, 32'd31, 30, 55, 1'b0);
    run_phase($urandom(), 32'd25, 210, 80, 1'b1);
    run_phase($urandom(), 32'd29, 50, 55, 1'b0);
    run_phase(32'h0000_0000, 32'd27, 60, 65, 1'b0);
    run_phase($urandom(), 32'd26, 50, 55, 1'b0);
    run_phase($urandom(), ($urandom() & 32'hFFFF_FFE0) | 32'd23, 40, 60, 1'b0);

    settle();
    if (ledger.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

// File: filelist.f
+incdir+rtl
rtl/apau_pkg.sv
rtl/apau_map_ram.sv
rtl/apau_word_scan.sv
rtl/ip_address_pool_allocator_unit.sv
tb/sv/tb_ip_address_pool_allocator_unit.sv
